### rtl/ddma_pkg.sv
// ----------------------------------------------------------------------------
// ddma_pkg
// Shared types and constants for the cascaded dma controller pair.
// ----------------------------------------------------------------------------
package ddma_pkg;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_D2M   = 2'd2;
   localparam logic [1:0] ACT_M2D   = 2'd3;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_CHAN  = 3'd1;
   localparam logic [2:0] KIND_MAIN  = 3'd2;
   localparam logic [2:0] KIND_LPAGE = 3'd3;
   localparam logic [2:0] KIND_HPAGE = 3'd4;

   localparam logic [2:0] MAIN_CMD    = 3'd0;
   localparam logic [2:0] MAIN_REQ    = 3'd1;
   localparam logic [2:0] MAIN_SMASK  = 3'd2;
   localparam logic [2:0] MAIN_MODE   = 3'd3;
   localparam logic [2:0] MAIN_FFCLR  = 3'd4;
   localparam logic [2:0] MAIN_RESET  = 3'd5;
   localparam logic [2:0] MAIN_UNMASK = 3'd6;
   localparam logic [2:0] MAIN_MASK   = 3'd7;

   localparam logic [1:0] TYPE_VERIFY = 2'd0;
   localparam logic [1:0] TYPE_D2M    = 2'd1;
   localparam logic [1:0] TYPE_M2D    = 2'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic       ctl;
      logic [3:0] off;
   } decode_type;

   // page slot for each page port offset, bit 3 set for reserved slots
   function automatic logic [3:0] page_slot(input logic [3:0] a);
      logic [3:0] s;
      case (a)
         4'd0:    s = 4'd2;
         4'd1:    s = 4'd3;
         4'd2:    s = 4'd1;
         4'd6:    s = 4'd0;
         4'd8:    s = 4'd6;
         4'd9:    s = 4'd7;
         4'd10:   s = 4'd5;
         default: s = 4'b1000;
      endcase
      return s;
   endfunction

   function automatic decode_type port_decode(input logic [10:0] p);
      decode_type d;
      d = '{kind: KIND_NONE, ctl: 1'b0, off: 4'd0};
      if (p <= 11'h007) begin
         d.kind = KIND_CHAN; d.off = p[3:0];
      end else if (p <= 11'h00f) begin
         d.kind = KIND_MAIN; d.off = {1'b0, p[2:0]};
      end else if (p >= 11'h081 && p <= 11'h08b) begin
         d.kind = KIND_LPAGE; d.off = 4'(p - 11'h081);
      end else if (p >= 11'h0c0 && p <= 11'h0cf) begin
         d.kind = KIND_CHAN; d.ctl = 1'b1; d.off = {1'b0, p[3:1]};
      end else if (p >= 11'h0d0 && p <= 11'h0df) begin
         d.kind = KIND_MAIN; d.ctl = 1'b1; d.off = {1'b0, p[3:1]};
      end else if (p >= 11'h481 && p <= 11'h48b) begin
         d.kind = KIND_HPAGE; d.off = 4'(p - 11'h481);
      end
      return d;
   endfunction

endpackage

### rtl/dual_dma_controller_with_page_registers.sv
// ----------------------------------------------------------------------------
// dual_dma_controller_with_page_registers
// Cascaded pair of 8237-style dma controllers with low and high page registers.
// ----------------------------------------------------------------------------
// One word is accepted per cycle whenever start is high (busy is always low);
// its result appears with rsp_valid in the following cycle, since the whole
// register access or transfer bookkeeping step is done between the input word
// and the result register. The receiver cannot stall, so results must be taken
// when shown.
module dual_dma_controller_with_page_registers (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [10:0] req_port,
   input  logic [7:0]  req_wdata,
   input  logic [2:0]  req_chan,
   input  logic [17:0] req_req_length,
   input  logic        req_eop_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_rdata,
   output logic        rsp_blocked,
   output logic        rsp_is_verify,
   output logic        rsp_tc_reached,
   output logic        rsp_eop_echo,
   output logic        rsp_error_flag,
   output logic [17:0] rsp_byte_count,
   output logic [31:0] rsp_start_address,
   output logic [17:0] rsp_first_segment_bytes,
   output logic        rsp_decrementing,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] base_addr_ff [8], base_addr_in [8];
   logic [15:0] cur_addr_ff  [8], cur_addr_in  [8];
   logic [15:0] base_cnt_ff  [8], base_cnt_in  [8];
   logic [15:0] cur_cnt_ff   [8], cur_cnt_in   [8];
   logic [7:0]  mode_ff      [8], mode_in      [8];
   logic [15:0] page_ff      [8], page_in      [8];
   logic [7:0]  cmd_ff  [2], cmd_in  [2];
   logic [3:0]  stat_ff [2], stat_in [2];
   logic [3:0]  reqb_ff [2], reqb_in [2];
   logic [3:0]  mask_ff [2], mask_in [2];
   logic        lbff_ff [2], lbff_in [2];
   logic        a32_ff;

   logic        valid_ff;
   logic [7:0]  rdata_ff, rdata_in;
   logic        blk_ff, blk_in, ver_ff, ver_in, tc_ff, tc_in, eop_ff, eop_in;
   logic        err_ff, err_in, dec_ff, dec_in;
   logic [17:0] bc_ff, bc_in, fs_ff, fs_in;
   logic [31:0] sa_ff, sa_in;

   ddma_pkg::decode_type dec;
   logic        go;

   assign busy  = 1'b0;
   assign go    = start;
   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {31'd0, a32_ff} : 32'd0;
   assign dec   = ddma_pkg::port_decode(req_port);

   always_comb begin
      logic [2:0]  n, ch3;
      logic        c;
      logic [3:0]  bit4, s;
      logic [1:0]  ch;
      logic [15:0] v;
      logic [7:0]  md;
      logic [1:0]  typ;
      logic        wide, isdec, tc, fin;
      logic [17:0] cnt, room, units;
      logic [16:0] cp1;
      logic [31:0] pg;
      base_addr_in = base_addr_ff; cur_addr_in = cur_addr_ff;
      base_cnt_in = base_cnt_ff; cur_cnt_in = cur_cnt_ff;
      mode_in = mode_ff; page_in = page_ff;
      cmd_in = cmd_ff; stat_in = stat_ff; reqb_in = reqb_ff;
      mask_in = mask_ff; lbff_in = lbff_ff;
      rdata_in = 8'd0; blk_in = 1'b0; ver_in = 1'b0; tc_in = 1'b0;
      eop_in = 1'b0; err_in = 1'b0; dec_in = 1'b0;
      bc_in = 18'd0; fs_in = 18'd0; sa_in = 32'd0;
      bit4 = 4'd0; md = 8'd0; typ = 2'd0; wide = 1'b0; isdec = 1'b0;
      tc = 1'b0; fin = 1'b0; cnt = 18'd0; room = 18'd0; units = 18'd0;
      cp1 = 17'd0; pg = 32'd0;
      c = dec.ctl;
      n = {c, dec.off[2:1]};
      ch = req_wdata[1:0];
      ch3 = {c, ch};
      s = ddma_pkg::page_slot(dec.off);
      v = 16'd0;
      if (go && req_action == ddma_pkg::ACT_READ) begin
         rdata_in = 8'hff;
         case (dec.kind)
            ddma_pkg::KIND_CHAN: begin
               v = dec.off[0] ? cur_cnt_ff[n] : cur_addr_ff[n];
               rdata_in = lbff_ff[c] ? v[7:0] : v[15:8];
               lbff_in[c] = !lbff_ff[c];
            end
            ddma_pkg::KIND_MAIN: begin
               if (dec.off[2:0] == ddma_pkg::MAIN_CMD) begin
                  rdata_in = {reqb_ff[c] | {3'd0, c && !cmd_ff[0][2] && (reqb_ff[0] != 4'd0)},
                              stat_ff[c]};
                  stat_in[c] = 4'd0;
               end else if (dec.off[2:0] == ddma_pkg::MAIN_MASK)
                  rdata_in = {4'd0, mask_ff[c]};
               else
                  rdata_in = 8'd0;
            end
            ddma_pkg::KIND_LPAGE, ddma_pkg::KIND_HPAGE: begin
               if (!s[3])
                  rdata_in = (dec.kind == ddma_pkg::KIND_HPAGE) ? page_ff[s[2:0]][15:8]
                                                                : page_ff[s[2:0]][7:0];
            end
            default: rdata_in = 8'hff;
         endcase
      end else if (go && req_action == ddma_pkg::ACT_WRITE) begin
         case (dec.kind)
            ddma_pkg::KIND_CHAN: begin
               if (dec.off[0]) begin
                  base_cnt_in[n] = lbff_ff[c] ? {base_cnt_ff[n][15:8], req_wdata}
                                              : {req_wdata, base_cnt_ff[n][7:0]};
                  cur_cnt_in[n] = base_cnt_in[n];
               end else begin
                  base_addr_in[n] = lbff_ff[c] ? {base_addr_ff[n][15:8], req_wdata}
                                               : {req_wdata, base_addr_ff[n][7:0]};
                  cur_addr_in[n] = base_addr_in[n];
               end
               lbff_in[c] = !lbff_ff[c];
            end
            ddma_pkg::KIND_MAIN: begin
               case (dec.off[2:0])
                  ddma_pkg::MAIN_CMD:   cmd_in[c] = req_wdata;
                  ddma_pkg::MAIN_REQ:   reqb_in[c][ch] = req_wdata[2];
                  ddma_pkg::MAIN_SMASK: mask_in[c][ch] = req_wdata[2];
                  ddma_pkg::MAIN_MODE:  mode_in[ch3] = req_wdata;
                  ddma_pkg::MAIN_FFCLR: lbff_in[c] = 1'b1;
                  ddma_pkg::MAIN_RESET: begin
                     lbff_in[c] = 1'b1; cmd_in[c] = 8'd0; stat_in[c] = 4'd0;
                     reqb_in[c] = 4'd0; mask_in[c] = 4'hf;
                  end
                  ddma_pkg::MAIN_UNMASK: mask_in[c] = 4'd0;
                  default: mask_in[c] = req_wdata[3:0];
               endcase
            end
            ddma_pkg::KIND_LPAGE: if (!s[3]) page_in[s[2:0]][7:0] = req_wdata;
            ddma_pkg::KIND_HPAGE: if (!s[3]) page_in[s[2:0]][15:8] = req_wdata;
            default: ;
         endcase
      end else if (go) begin
         n = req_chan;
         c = n[2];
         bit4 = 4'b0001 << n[1:0];
         wide = c;
         md = mode_ff[n];
         typ = md[3:2];
         cp1 = {1'b0, cur_cnt_ff[n]} + 17'd1;
         cnt = wide ? {cp1, 1'b0} : {1'b0, cp1};
         if (req_req_length != 18'd0 && req_req_length < cnt) cnt = req_req_length;
         if (n == 3'd4)
            err_in = 1'b1;
         else if (cmd_ff[c][2]
                  || ((mask_ff[c] & bit4) != 4'd0 && (reqb_ff[c] & bit4) == 4'd0)
                  || md[7:6] == 2'b11
                  || (typ != ddma_pkg::TYPE_VERIFY
                      && typ != ((req_action == ddma_pkg::ACT_D2M) ? ddma_pkg::TYPE_D2M
                                                                   : ddma_pkg::TYPE_M2D)))
            blk_in = 1'b1;
         else if (wide && cnt[0])
            err_in = 1'b1;
         else begin
            units = wide ? {1'b0, cnt[17:1]} : cnt;
            tc = units == {1'b0, cp1};
            fin = tc || req_eop_in;
            isdec = md[5];
            eop_in = req_eop_in;
            tc_in = tc;
            if (typ == ddma_pkg::TYPE_VERIFY)
               ver_in = 1'b1;
            else begin
               pg = a32_ff ? {16'd0, page_ff[n]} : {24'd0, page_ff[n][7:0]};
               if (wide) pg[0] = 1'b0;
               room = isdec ? ({2'd0, cur_addr_ff[n]} + 18'd1)
                            : (18'h10000 - {2'd0, cur_addr_ff[n]});
               if (wide) room = room << 1;
               bc_in = cnt;
               sa_in = {pg[15:0], 16'd0} | (wide ? {15'd0, cur_addr_ff[n], 1'b0}
                                                 : {16'd0, cur_addr_ff[n]});
               fs_in = (cnt < room) ? cnt : room;
               dec_in = isdec;
            end
            cur_addr_in[n] = isdec ? cur_addr_ff[n] - units[15:0]
                                   : cur_addr_ff[n] + units[15:0];
            cur_cnt_in[n] = cur_cnt_ff[n] - units[15:0];
            if (fin) begin
               stat_in[c] = stat_ff[c] | bit4;
               reqb_in[c] = reqb_ff[c] & ~bit4;
               if (md[4]) begin
                  cur_addr_in[n] = base_addr_ff[n];
                  cur_cnt_in[n] = base_cnt_ff[n];
               end else
                  mask_in[c] = mask_ff[c] | bit4;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            base_addr_ff[i] <= 16'd0; cur_addr_ff[i] <= 16'd0;
            base_cnt_ff[i] <= 16'd0; cur_cnt_ff[i] <= 16'd0;
            mode_ff[i] <= 8'd0; page_ff[i] <= 16'd0;
         end
         for (int i = 0; i < 2; i++) begin
            cmd_ff[i] <= 8'd0; stat_ff[i] <= 4'd0; reqb_ff[i] <= 4'd0;
            mask_ff[i] <= 4'hf; lbff_ff[i] <= 1'b1;
         end
         valid_ff <= 1'b0;
         a32_ff <= 1'b0;
      end else begin
         base_addr_ff <= base_addr_in; cur_addr_ff <= cur_addr_in;
         base_cnt_ff <= base_cnt_in; cur_cnt_ff <= cur_cnt_in;
         mode_ff <= mode_in; page_ff <= page_in;
         cmd_ff <= cmd_in; stat_ff <= stat_in; reqb_ff <= reqb_in;
         mask_ff <= mask_in; lbff_ff <= lbff_in;
         valid_ff <= go;
         if (psel && penable && pwrite && paddr == 2'd0) a32_ff <= pwdata[0];
      end
      rdata_ff <= rdata_in; blk_ff <= blk_in; ver_ff <= ver_in; tc_ff <= tc_in;
      eop_ff <= eop_in; err_ff <= err_in; dec_ff <= dec_in;
      bc_ff <= bc_in; fs_ff <= fs_in; sa_ff <= sa_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_rdata = rdata_ff;
   assign rsp_blocked = blk_ff;
   assign rsp_is_verify = ver_ff;
   assign rsp_tc_reached = tc_ff;
   assign rsp_eop_echo = eop_ff;
   assign rsp_error_flag = err_ff;
   assign rsp_byte_count = bc_ff;
   assign rsp_start_address = sa_ff;
   assign rsp_first_segment_bytes = fs_ff;
   assign rsp_decrementing = dec_ff;

endmodule

### rtl/ddma_checker.sv
// ----------------------------------------------------------------------------
// ddma_checker
// Port-level checks for the cascaded dma controller pair.
// ----------------------------------------------------------------------------
module ddma_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_blocked,
   input logic        rsp_error_flag,
   input logic        rsp_is_verify,
   input logic [17:0] rsp_byte_count
);
   a_one_per_word: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid) else $error("missing result");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid) else $error("extra result");
   a_blk_err: assert property (@(posedge clock) disable iff (reset)
      !(rsp_blocked && rsp_error_flag)) else $error("blocked and error");
   a_blk_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_blocked || rsp_is_verify) |-> rsp_byte_count == 18'd0)
      else $error("count on blocked or verify");
endmodule

bind dual_dma_controller_with_page_registers ddma_checker u_ddma_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_blocked(rsp_blocked),
   .rsp_error_flag(rsp_error_flag), .rsp_is_verify(rsp_is_verify),
   .rsp_byte_count(rsp_byte_count));

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the cascaded dma controller pair word by word against a behavioral
// model of its registers: port reads and writes, channel programming and
// transfer bookkeeping, under random gaps and both address modes.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        blocked;
      logic        is_verify;
      logic        tc_reached;
      logic        eop_echo;
      logic        error_flag;
      logic [17:0] byte_count;
      logic [31:0] start_address;
      logic [17:0] first_segment_bytes;
      logic        decrementing;
   } dma_result_type;

   class dma_scoreboard;
      logic        addr32;
      logic [15:0] base_addr[8];
      logic [15:0] cur_addr[8];
      logic [15:0] base_cnt[8];
      logic [15:0] cur_cnt[8];
      logic [7:0]  chan_mode[8];
      logic [15:0] page_reg[8];
      logic [7:0]  cmd[2];
      logic [3:0]  status[2];
      logic [3:0]  sw_req[2];
      logic [3:0]  mask[2];
      logic        low_next[2];
      dma_result_type expected[$];
      int          errors;

      function new();
         addr32 = 1'b0;
         errors = 0;
         for (int i = 0; i < 8; i++) begin
            base_addr[i] = '0; cur_addr[i] = '0; base_cnt[i] = '0;
            cur_cnt[i] = '0; chan_mode[i] = '0; page_reg[i] = '0;
         end
         for (int i = 0; i < 2; i++) begin
            cmd[i] = '0; status[i] = '0; sw_req[i] = '0;
            mask[i] = 4'hf; low_next[i] = 1'b1;
         end
      endfunction

      function int page_index(int a);
         case (a)
            0: return 2;
            1: return 3;
            2: return 1;
            6: return 0;
            8: return 6;
            9: return 7;
            10: return 5;
            default: return -1;
         endcase
      endfunction

      function void decode(logic [10:0] p, output logic [2:0] kind, output int c,
                           output int a);
         kind = ddma_pkg::KIND_NONE; c = 0; a = 0;
         if (p <= 11'h007) begin
            kind = ddma_pkg::KIND_CHAN; a = p;
         end else if (p <= 11'h00f) begin
            kind = ddma_pkg::KIND_MAIN; a = p - 8;
         end else if (p >= 11'h081 && p <= 11'h08b) begin
            kind = ddma_pkg::KIND_LPAGE; a = p - 11'h081;
         end else if (p >= 11'h0c0 && p <= 11'h0cf) begin
            kind = ddma_pkg::KIND_CHAN; c = 1; a = (p - 11'h0c0) >> 1;
         end else if (p >= 11'h0d0 && p <= 11'h0df) begin
            kind = ddma_pkg::KIND_MAIN; c = 1; a = (p - 11'h0d0) >> 1;
         end else if (p >= 11'h481 && p <= 11'h48b) begin
            kind = ddma_pkg::KIND_HPAGE; a = p - 11'h481;
         end
      endfunction

      function logic [7:0] port_read(logic [10:0] p);
         logic [2:0]  kind;
         int          c, a, n, s;
         logic [15:0] v;
         logic [3:0]  pend;
         decode(p, kind, c, a);
         case (kind)
            ddma_pkg::KIND_CHAN: begin
               n = (a >> 1) + c * 4;
               v = a[0] ? cur_cnt[n] : cur_addr[n];
               if (!low_next[c]) v = v >> 8;
               low_next[c] = ~low_next[c];
               return v[7:0];
            end
            ddma_pkg::KIND_MAIN: begin
               if (a == ddma_pkg::MAIN_CMD) begin
                  pend = sw_req[c];
                  if (c == 1 && !cmd[0][2] && sw_req[0] != 0) pend[0] = 1'b1;
                  v = {8'h00, pend, status[c]};
                  status[c] = '0;
                  return v[7:0];
               end
               if (a == ddma_pkg::MAIN_MASK) return {4'h0, mask[c]};
               return 8'h00;
            end
            ddma_pkg::KIND_LPAGE, ddma_pkg::KIND_HPAGE: begin
               s = page_index(a);
               if (s < 0) return 8'hff;
               v = page_reg[s];
               if (p >= 11'h400) v = v >> 8;
               return v[7:0];
            end
            default: return 8'hff;
         endcase
      endfunction

      function void port_write(logic [10:0] p, logic [7:0] d);
         logic [2:0] kind;
         int         c, a, n, s;
         logic [1:0] ch;
         decode(p, kind, c, a);
         ch = d[1:0];
         case (kind)
            ddma_pkg::KIND_CHAN: begin
               n = (a >> 1) + c * 4;
               if (a[0]) begin
                  if (low_next[c]) base_cnt[n][7:0] = d; else base_cnt[n][15:8] = d;
                  cur_cnt[n] = base_cnt[n];
               end else begin
                  if (low_next[c]) base_addr[n][7:0] = d; else base_addr[n][15:8] = d;
                  cur_addr[n] = base_addr[n];
               end
               low_next[c] = ~low_next[c];
            end
            ddma_pkg::KIND_MAIN: begin
               case (a)
                  ddma_pkg::MAIN_CMD:    cmd[c] = d;
                  ddma_pkg::MAIN_REQ:    sw_req[c][ch] = d[2];
                  ddma_pkg::MAIN_SMASK:  mask[c][ch] = d[2];
                  ddma_pkg::MAIN_MODE:   chan_mode[c * 4 + ch] = d;
                  ddma_pkg::MAIN_FFCLR:  low_next[c] = 1'b1;
                  ddma_pkg::MAIN_RESET: begin
                     low_next[c] = 1'b1; cmd[c] = '0; status[c] = '0;
                     sw_req[c] = '0; mask[c] = 4'hf;
                  end
                  ddma_pkg::MAIN_UNMASK: mask[c] = '0;
                  default:     mask[c] = d[3:0];
               endcase
            end
            ddma_pkg::KIND_LPAGE, ddma_pkg::KIND_HPAGE: begin
               s = page_index(a);
               if (s >= 0) begin
                  if (p >= 11'h400) page_reg[s][15:8] = d; else page_reg[s][7:0] = d;
               end
            end
            default: ;
         endcase
      endfunction

      function logic step_channel(int n, int unsigned units, logic eop);
         int   c;
         logic tc;
         c = n >> 2;
         tc = (units == int'(cur_cnt[n]) + 1);
         if (chan_mode[n][5]) cur_addr[n] = cur_addr[n] - units[15:0];
         else cur_addr[n] = cur_addr[n] + units[15:0];
         cur_cnt[n] = cur_cnt[n] - units[15:0];
         if (tc || eop) begin
            status[c][n & 3] = 1'b1;
            sw_req[c][n & 3] = 1'b0;
            if (chan_mode[n][4]) begin
               cur_addr[n] = base_addr[n];
               cur_cnt[n] = base_cnt[n];
            end else begin
               mask[c][n & 3] = 1'b1;
            end
         end
         return tc;
      endfunction

      function void note_request(logic [1:0] act, logic [10:0] p, logic [7:0] wd,
                                 logic [2:0] ch, logic [17:0] len, logic eop);
         dma_result_type r;
         int             c, n, wid;
         logic [7:0]     md;
         logic [1:0]     kind, want;
         int unsigned    cnt, pg, cur, room;
         logic [63:0]    addr;
         r = '0;
         n = ch;
         if (act == ddma_pkg::ACT_READ) begin
            r.rdata = port_read(p);
         end else if (act == ddma_pkg::ACT_WRITE) begin
            port_write(p, wd);
         end else if (ch == 3'd4) begin
            r.error_flag = 1'b1;
         end else begin
            c = n >> 2;
            wid = (n < 4) ? 1 : 2;
            md = chan_mode[n];
            kind = md[3:2];
            want = (act == ddma_pkg::ACT_D2M) ? ddma_pkg::TYPE_D2M : ddma_pkg::TYPE_M2D;
            if (cmd[c][2] || (mask[c][n & 3] && !sw_req[c][n & 3]) || md[7:6] == 2'b11 ||
                (kind != ddma_pkg::TYPE_VERIFY && kind != want)) begin
               r.blocked = 1'b1;
            end else begin
               cnt = (int'(cur_cnt[n]) + 1) * wid;
               if (len > 0 && len < cnt) cnt = len;
               if (cnt % wid != 0) begin
                  r.error_flag = 1'b1;
               end else begin
                  r.eop_echo = eop;
                  if (kind == ddma_pkg::TYPE_VERIFY) begin
                     r.is_verify = 1'b1;
                     r.tc_reached = step_channel(n, cnt / wid, eop);
                  end else begin
                     pg = addr32 ? page_reg[n] : page_reg[n] & 16'h00ff;
                     cur = cur_addr[n];
                     room = md[5] ? (cur + 1) * wid : (32'h10000 - cur) * wid;
                     if (wid == 2) pg = pg & 16'hfffe;
                     addr = (64'(pg) << 16) | 64'(cur * wid);
                     r.byte_count = cnt[17:0];
                     r.start_address = addr[31:0];
                     r.first_segment_bytes = (cnt < room) ? cnt[17:0] : room[17:0];
                     r.decrementing = md[5];
                     r.tc_reached = step_channel(n, cnt / wid, eop);
                  end
               end
            end
         end
         expected.push_back(r);
      endfunction

      task report(string field, longint got, longint want_v);
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want_v);
         errors++;
      endtask

      task check_result(dma_result_type got);
         dma_result_type e;
         if (expected.size() == 0) begin
            $display("unexpected word at %0t", $time);
            errors++;
            return;
         end
         e = expected.pop_front();
         if (got.rdata !== e.rdata) report("rdata", got.rdata, e.rdata);
         if (got.blocked !== e.blocked) report("blocked", got.blocked, e.blocked);
         if (got.is_verify !== e.is_verify) report("is_verify", got.is_verify, e.is_verify);
         if (got.tc_reached !== e.tc_reached)
            report("tc_reached", got.tc_reached, e.tc_reached);
         if (got.eop_echo !== e.eop_echo) report("eop_echo", got.eop_echo, e.eop_echo);
         if (got.error_flag !== e.error_flag)
            report("error_flag", got.error_flag, e.error_flag);
         if (got.byte_count !== e.byte_count)
            report("byte_count", got.byte_count, e.byte_count);
         if (got.start_address !== e.start_address)
            report("start_address", got.start_address, e.start_address);
         if (got.first_segment_bytes !== e.first_segment_bytes)
            report("first_segment_bytes", got.first_segment_bytes, e.first_segment_bytes);
         if (got.decrementing !== e.decrementing)
            report("decrementing", got.decrementing, e.decrementing);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic [10:0] req_port = '0;
   logic [7:0]  req_wdata = '0;
   logic [2:0]  req_chan = '0;
   logic [17:0] req_req_length = '0;
   logic        req_eop_in = 1'b0;
   logic        rsp_valid;
   dma_result_type rsp;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   dma_scoreboard sb = new();
   int          items_sent = 0;
   int          quiet_cycles = 0;
   bit          gaps_on = 1'b1;

   always #5 clock = ~clock;

   dual_dma_controller_with_page_registers dut (
      .clock, .reset, .start, .busy,
      .req_action, .req_port, .req_wdata, .req_chan, .req_req_length, .req_eop_in,
      .rsp_valid,
      .rsp_rdata(rsp.rdata), .rsp_blocked(rsp.blocked), .rsp_is_verify(rsp.is_verify),
      .rsp_tc_reached(rsp.tc_reached), .rsp_eop_echo(rsp.eop_echo),
      .rsp_error_flag(rsp.error_flag), .rsp_byte_count(rsp.byte_count),
      .rsp_start_address(rsp.start_address),
      .rsp_first_segment_bytes(rsp.first_segment_bytes),
      .rsp_decrementing(rsp.decrementing),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp);
         if (start && !busy)
            sb.note_request(req_action, req_port, req_wdata, req_chan, req_req_length,
                            req_eop_in);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == 2000) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task send(logic [1:0] act, logic [10:0] p, logic [7:0] d, logic [2:0] ch,
             logic [17:0] len, logic eop);
      bit taken;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_port <= p;
      req_wdata <= d;
      req_chan <= ch;
      req_req_length <= len;
      req_eop_in <= eop;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   task wr_port(logic [10:0] p, logic [7:0] d);
      send(ddma_pkg::ACT_WRITE, p, d, 3'($urandom), 18'($urandom), 1'($urandom));
   endtask

   task rd_port(logic [10:0] p);
      send(ddma_pkg::ACT_READ, p, 8'($urandom), 3'($urandom), 18'($urandom), 1'($urandom));
   endtask

   task wait_idle;
      start <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task write_addr_mode(logic v);
      wait_idle();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= {31'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
      sb.addr32 = v;
   endtask

   function logic [10:0] main_port(int c, logic [2:0] off);
      return (c == 0) ? 11'(11'h008 + off) : 11'(11'h0d0 + 2 * off);
   endfunction

   function logic [10:0] page_port(int n);
      case (n)
         0: return 11'h087;
         1: return 11'h083;
         2: return 11'h081;
         3: return 11'h082;
         5: return 11'h08b;
         6: return 11'h089;
         default: return 11'h08a;
      endcase
   endfunction

   task setup_channel(int n, logic [15:0] addr, logic [15:0] cnt, logic [7:0] md,
                      logic [15:0] pg);
      int         c, k;
      logic [10:0] ap, cp;
      c = n >> 2;
      k = n & 3;
      ap = (c == 0) ? 11'(2 * k) : 11'(11'h0c0 + 4 * k);
      cp = (c == 0) ? 11'(2 * k + 1) : 11'(11'h0c2 + 4 * k);
      wr_port(main_port(c, ddma_pkg::MAIN_FFCLR), 8'($urandom));
      wr_port(ap, addr[7:0]);
      wr_port(ap, addr[15:8]);
      wr_port(cp, cnt[7:0]);
      wr_port(cp, cnt[15:8]);
      if (n != 4) begin
         wr_port(page_port(n), pg[7:0]);
         wr_port(page_port(n) + 11'h400, pg[15:8]);
      end
      wr_port(main_port(c, ddma_pkg::MAIN_MODE), {md[7:2], k[1:0]});
      wr_port(main_port(c, ddma_pkg::MAIN_SMASK), {6'd0, k[1:0]});
   endtask

   function logic [7:0] pick_mode();
      logic [7:0] m;
      m = 8'($urandom);
      if ($urandom_range(0, 5) != 0 && m[7:6] == 2'b11) m[7:6] = 2'b01;
      return m;
   endfunction

   task random_sequence;
      int          n, reps;
      logic [15:0] addr, cnt;
      n = $urandom_range(0, 7);
      if (n == 4 && $urandom_range(0, 3) != 0) n = 5;
      addr = $urandom_range(0, 3) == 0 ? (($urandom & 1) ? 16'(16'hfffc + $urandom_range(0, 3))
                                                          : 16'($urandom_range(0, 3)))
                                       : 16'($urandom);
      cnt = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20));
      if ($urandom_range(0, 7) == 0)
         wr_port(main_port(n >> 2, ddma_pkg::MAIN_CMD),
                 $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00);
      setup_channel(n, addr, cnt, pick_mode(), 16'($urandom));
      if ($urandom_range(0, 5) == 0) begin
         wr_port(main_port(n >> 2, ddma_pkg::MAIN_SMASK), {6'd1, 2'(n & 3)});
         wr_port(main_port(n >> 2, ddma_pkg::MAIN_REQ), {6'd1, 2'(n & 3)});
      end
      reps = $urandom_range(1, 6);
      repeat (reps) begin
         send(2'($urandom_range(ddma_pkg::ACT_D2M, ddma_pkg::ACT_M2D)), 11'($urandom),
              8'($urandom), 3'(n),
              $urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 12)),
              $urandom_range(0, 5) == 0);
      end
      if ($urandom_range(0, 2) == 0) rd_port(main_port(n >> 2, ddma_pkg::MAIN_CMD));
      if ($urandom_range(0, 3) == 0) rd_port(main_port(n >> 2, ddma_pkg::MAIN_MASK));
      if ($urandom_range(0, 3) == 0) rd_port($urandom_range(0, 1) ? 11'($urandom_range(0, 7))
                                                                  : 11'($urandom_range(192, 207)));
   endtask

   task random_noise;
      case ($urandom_range(0, 3))
         0: rd_port(11'($urandom));
         1: rd_port($urandom_range(0, 1) ? 11'($urandom_range(0, 255))
                                         : 11'($urandom_range(11'h480, 11'h48f)));
         2: wr_port($urandom_range(0, 1) ? 11'($urandom_range(0, 255)) : 11'($urandom),
                    8'($urandom));
         default: send(2'($urandom), 11'($urandom), 8'($urandom), 3'($urandom),
                       18'($urandom), 1'($urandom));
      endcase
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: masked channel, verify, cascade, word channels, wrap, channel 4
      send(ddma_pkg::ACT_D2M, 0, 0, 3'd1, 0, 0);
      send(ddma_pkg::ACT_M2D, 0, 0, 3'd4, 0, 0);
      setup_channel(1, 16'hfffe, 16'd5, 8'h44, 16'hffff);
      send(ddma_pkg::ACT_D2M, 0, 0, 3'd1, 18'd4, 1'b0);
      send(ddma_pkg::ACT_D2M, 0, 0, 3'd1, 18'd0, 1'b1);
      setup_channel(5, 16'h0001, 16'hffff, 8'h28, 16'h12ab);
      send(ddma_pkg::ACT_M2D, 0, 0, 3'd5, 18'd3, 1'b0);
      send(ddma_pkg::ACT_M2D, 0, 0, 3'd5, 18'h3ffff, 1'b0);
      setup_channel(2, 16'h0010, 16'd3, 8'h10, 16'h00ff);
      send(ddma_pkg::ACT_D2M, 0, 0, 3'd2, 18'd0, 1'b0);
      rd_port(11'h008);
      rd_port(11'h0d0);
      rd_port(11'h00f);
      rd_port(11'h40b);
      rd_port(11'h4d6);
      rd_port(11'h7ff);
      write_addr_mode(1'b1);
      setup_channel(7, 16'h8000, 16'd2, 8'hc8, 16'hff01);
      send(ddma_pkg::ACT_M2D, 0, 0, 3'd7, 18'd0, 1'b0);
      wr_port(11'h0d8, 8'h00);
      setup_channel(6, 16'h8000, 16'd2, 8'h08, 16'hff01);
      send(ddma_pkg::ACT_M2D, 0, 0, 3'd6, 18'd0, 1'b0);

      while (items_sent < 1000) begin
         if (items_sent > 250 && items_sent < 270) write_addr_mode(1'b0);
         if (items_sent > 550 && items_sent < 570) write_addr_mode(1'b1);
         gaps_on = items_sent < 850;
         if ($urandom_range(0, 3) == 0) random_noise();
         else random_sequence();
      end
      write_addr_mode(1'b0);
      setup_channel(3, 16'hffff, 16'd1, 8'h24, 16'h0080);
      send(ddma_pkg::ACT_D2M, 0, 0, 3'd3, 18'd0, 1'b0);

      wait_idle();
      repeat (5) @(posedge clock);
      if (sb.errors == 0 && sb.expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/ddma_pkg.sv
rtl/dual_dma_controller_with_page_registers.sv
rtl/ddma_checker.sv
test/tb.sv
